/* hw/rtl/upn_pkg.sv */
// Shared constants for the unit plane normal block.
`default_nettype none
package upn_pkg;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_BITS = 30;
  localparam int unsigned QUOT_W    = FRAC_BITS + 1;
  localparam int unsigned LANES     = 3;
  localparam logic [QUOT_W-1:0] ONE_Q30 = QUOT_W'(1) << FRAC_BITS;
endpackage
`default_nettype wire

/* hw/rtl/upn_if.sv */
// Valid/ready channel interfaces for vector pair items and normal items.
`default_nettype none
interface upn_in_if;
  logic valid;
  logic ready;
  logic signed [upn_pkg::DATA_W-1:0] first_x;
  logic signed [upn_pkg::DATA_W-1:0] first_y;
  logic signed [upn_pkg::DATA_W-1:0] first_z;
  logic signed [upn_pkg::DATA_W-1:0] second_x;
  logic signed [upn_pkg::DATA_W-1:0] second_y;
  logic signed [upn_pkg::DATA_W-1:0] second_z;
  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  input ready);
  modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                output ready);
endinterface

interface upn_out_if;
  logic valid;
  logic ready;
  logic signed [upn_pkg::DATA_W-1:0] normal_x;
  logic signed [upn_pkg::DATA_W-1:0] normal_y;
  logic signed [upn_pkg::DATA_W-1:0] normal_z;
  logic degenerate;
  modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface
`default_nettype wire

/* hw/rtl/upn_sqrt_cell.sv */
// One digit cell of the pipelined integer square root chain.
`default_nettype none
module upn_sqrt_cell #(
  parameter int unsigned RW = 64,
  parameter int unsigned MW = 64
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                en_i,
  input  wire logic                                valid_i,
  input  wire logic [2*RW-1:0]                     s_i,
  input  wire logic [RW+1:0]                       rem_i,
  input  wire logic [RW-1:0]                       root_i,
  input  wire logic [upn_pkg::LANES-1:0][MW-1:0]   mag_i,
  input  wire logic [upn_pkg::LANES-1:0]           neg_i,
  output logic                                     valid_o,
  output logic [2*RW-1:0]                          s_o,
  output logic [RW+1:0]                            rem_o,
  output logic [RW-1:0]                            root_o,
  output logic [upn_pkg::LANES-1:0][MW-1:0]        mag_o,
  output logic [upn_pkg::LANES-1:0]                neg_o
);
  localparam int unsigned SW = 2 * RW;

  logic [RW+3:0] rem_x, trial, rem_sub;
  logic          ge;

  always_comb begin
    rem_x   = {rem_i, s_i[SW-1 -: 2]};
    trial   = {2'b00, root_i, 2'b01};
    ge      = (rem_x >= trial);
    rem_sub = ge ? (rem_x - trial) : rem_x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_o    <= {s_i[SW-3:0], 2'b00};
      rem_o  <= rem_sub[RW+1:0];
      root_o <= {root_i[RW-2:0], ge};
      mag_o  <= mag_i;
      neg_o  <= neg_i;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/upn_div_cell.sv */
// One quotient-bit cell of the pipelined restoring divider, three lanes wide.
`default_nettype none
module upn_div_cell #(
  parameter int unsigned RW = 64
) (
  input  wire logic                                           clk_i,
  input  wire logic                                           rst_ni,
  input  wire logic                                           en_i,
  input  wire logic                                           valid_i,
  input  wire logic [RW-1:0]                                  n_i,
  input  wire logic [upn_pkg::LANES-1:0][RW-1:0]              r_i,
  input  wire logic [upn_pkg::LANES-1:0][upn_pkg::QUOT_W-1:0] q_i,
  input  wire logic [upn_pkg::LANES-1:0]                      neg_i,
  input  wire logic                                           deg_i,
  output logic                                                valid_o,
  output logic [RW-1:0]                                       n_o,
  output logic [upn_pkg::LANES-1:0][RW-1:0]                   r_o,
  output logic [upn_pkg::LANES-1:0][upn_pkg::QUOT_W-1:0]      q_o,
  output logic [upn_pkg::LANES-1:0]                           neg_o,
  output logic                                                deg_o
);
  localparam int unsigned QW = upn_pkg::QUOT_W;

  logic [upn_pkg::LANES-1:0][RW:0]     r2, r_sub;
  logic [upn_pkg::LANES-1:0]           ge;

  always_comb begin
    for (int l = 0; l < upn_pkg::LANES; l++) begin
      r2[l]    = {r_i[l], 1'b0};
      ge[l]    = (r2[l] >= {1'b0, n_i});
      r_sub[l] = ge[l] ? (r2[l] - {1'b0, n_i}) : r2[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_o   <= n_i;
      neg_o <= neg_i;
      deg_o <= deg_i;
      for (int l = 0; l < upn_pkg::LANES; l++) begin
        r_o[l] <= r_sub[l][RW-1:0];
        q_o[l] <= {q_i[l][QW-2:0], ge[l]};
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/unit_plane_normal.sv */
// Throughput: one item per cycle; every stage moves together whenever the output
// register is empty or being taken, so a stall on the output holds the whole chain.
// The square root chain has one cell per root bit, the divider one cell per fraction bit.
// Reset clears all valid flags; payload registers are not reset.
`default_nettype none
module unit_plane_normal #(
  parameter int unsigned COMPONENT_WIDTH = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  upn_in_if.sink     in_i,
  upn_out_if.source  out_o
);
  localparam int unsigned EW = (COMPONENT_WIDTH < 32) ? COMPONENT_WIDTH : 32;
  localparam int unsigned PW = 2 * EW;
  localparam int unsigned CW = 2 * EW + 1;
  localparam int unsigned MW = 2 * EW;
  localparam int unsigned SW = 4 * EW;
  localparam int unsigned RW = 2 * EW;
  localparam int unsigned NL = upn_pkg::LANES;
  localparam int unsigned QW = upn_pkg::QUOT_W;
  localparam int unsigned ND = upn_pkg::FRAC_BITS;
  localparam int unsigned DW = upn_pkg::DATA_W;

  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // Stage 1: six cross products.
  logic signed [EW-1:0] ax, ay, az, bx, by, bz;
  logic signed [PW-1:0] prod_d [6];
  logic signed [PW-1:0] prod_q [6];
  logic                 v1_q;

  always_comb begin
    ax = in_i.first_x[EW-1:0];
    ay = in_i.first_y[EW-1:0];
    az = in_i.first_z[EW-1:0];
    bx = in_i.second_x[EW-1:0];
    by = in_i.second_y[EW-1:0];
    bz = in_i.second_z[EW-1:0];
    prod_d[0] = PW'(ay) * PW'(bz);
    prod_d[1] = PW'(az) * PW'(by);
    prod_d[2] = PW'(az) * PW'(bx);
    prod_d[3] = PW'(ax) * PW'(bz);
    prod_d[4] = PW'(ax) * PW'(by);
    prod_d[5] = PW'(ay) * PW'(bx);
  end

  // Stage 2: differences, magnitudes and signs.
  logic [CW-1:0]          cdiff [NL];
  logic [CW-1:0]          cabs  [NL];
  logic [NL-1:0][MW-1:0]  mag2_d, mag2_q;
  logic [NL-1:0]          neg2_d, neg2_q;
  logic                   v2_q;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      cdiff[l]  = {prod_q[2*l][PW-1], prod_q[2*l]} - {prod_q[2*l+1][PW-1], prod_q[2*l+1]};
      neg2_d[l] = cdiff[l][CW-1];
      cabs[l]   = neg2_d[l] ? (~cdiff[l] + CW'(1)) : cdiff[l];
      mag2_d[l] = cabs[l][MW-1:0];
    end
  end

  // Stage 3: partial squares from half-width products.
  logic [NL-1:0][PW-1:0] hh_d, hl_d, ll_d, hh_q, hl_q, ll_q;
  logic [NL-1:0][MW-1:0] mag3_q;
  logic [NL-1:0]         neg3_q;
  logic                  v3_q;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      hh_d[l] = PW'(mag2_q[l][MW-1:EW]) * PW'(mag2_q[l][MW-1:EW]);
      hl_d[l] = PW'(mag2_q[l][MW-1:EW]) * PW'(mag2_q[l][EW-1:0]);
      ll_d[l] = PW'(mag2_q[l][EW-1:0]) * PW'(mag2_q[l][EW-1:0]);
    end
  end

  // Stage 4: full squares.  Stage 5: sum of squares.
  logic [NL-1:0][SW-1:0] sq_d, sq_q;
  logic [NL-1:0][MW-1:0] mag4_q, mag5_q;
  logic [NL-1:0]         neg4_q, neg5_q;
  logic [SW-1:0]         sum_q;
  logic                  v4_q, v5_q;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      sq_d[l] = {hh_q[l], ll_q[l]} + (SW'(hl_q[l]) << (EW + 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= prod_d;
      mag2_q <= mag2_d;
      neg2_q <= neg2_d;
      hh_q   <= hh_d;
      hl_q   <= hl_d;
      ll_q   <= ll_d;
      mag3_q <= mag2_q;
      neg3_q <= neg2_q;
      sq_q   <= sq_d;
      mag4_q <= mag3_q;
      neg4_q <= neg3_q;
      sum_q  <= sq_q[0] + sq_q[1] + sq_q[2];
      mag5_q <= mag4_q;
      neg5_q <= neg4_q;
    end
  end

  // Square root chain, two bits of the sum per cell.
  logic                  sv   [RW+1];
  logic [SW-1:0]         ss   [RW+1];
  logic [RW+1:0]         srem [RW+1];
  logic [RW-1:0]         sroot[RW+1];
  logic [NL-1:0][MW-1:0] smag [RW+1];
  logic [NL-1:0]         sneg [RW+1];

  assign sv[0]    = v5_q;
  assign ss[0]    = sum_q;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign smag[0]  = mag5_q;
  assign sneg[0]  = neg5_q;

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    upn_sqrt_cell #(.RW(RW), .MW(MW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sv[k]),
      .s_i     (ss[k]),
      .rem_i   (srem[k]),
      .root_i  (sroot[k]),
      .mag_i   (smag[k]),
      .neg_i   (sneg[k]),
      .valid_o (sv[k+1]),
      .s_o     (ss[k+1]),
      .rem_o   (srem[k+1]),
      .root_o  (sroot[k+1]),
      .mag_o   (smag[k+1]),
      .neg_o   (sneg[k+1])
    );
  end

  // Divider setup. The root never falls below any magnitude, so the integer
  // quotient is one exactly when they are equal and the remainder is then zero.
  logic                  pv_q;
  logic [RW-1:0]         pn_q;
  logic [NL-1:0][RW-1:0] pr_d, pr_q;
  logic [NL-1:0][QW-1:0] pq_d, pq_q;
  logic [NL-1:0]         pneg_q;
  logic                  pdeg_q;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      if (smag[RW][l] == sroot[RW]) begin
        pq_d[l] = QW'(1);
        pr_d[l] = '0;
      end else begin
        pq_d[l] = '0;
        pr_d[l] = smag[RW][l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en) begin
      pv_q <= sv[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pn_q   <= sroot[RW];
      pr_q   <= pr_d;
      pq_q   <= pq_d;
      pneg_q <= sneg[RW];
      pdeg_q <= (sroot[RW] == '0);
    end
  end

  // Divider chain, one fraction bit per cell.
  logic                  dv  [ND+1];
  logic [RW-1:0]         dn  [ND+1];
  logic [NL-1:0][RW-1:0] dr  [ND+1];
  logic [NL-1:0][QW-1:0] dq  [ND+1];
  logic [NL-1:0]         dneg[ND+1];
  logic                  ddeg[ND+1];

  assign dv[0]   = pv_q;
  assign dn[0]   = pn_q;
  assign dr[0]   = pr_q;
  assign dq[0]   = pq_q;
  assign dneg[0] = pneg_q;
  assign ddeg[0] = pdeg_q;

  for (genvar k = 0; k < ND; k++) begin : g_div
    upn_div_cell #(.RW(RW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[k]),
      .n_i     (dn[k]),
      .r_i     (dr[k]),
      .q_i     (dq[k]),
      .neg_i   (dneg[k]),
      .deg_i   (ddeg[k]),
      .valid_o (dv[k+1]),
      .n_o     (dn[k+1]),
      .r_o     (dr[k+1]),
      .q_o     (dq[k+1]),
      .neg_o   (dneg[k+1]),
      .deg_o   (ddeg[k+1])
    );
  end

  // Output register: clamp, restore sign, zero the normal on a degenerate pair.
  logic [QW-1:0]         qc   [NL];
  logic [NL-1:0][DW-1:0] nrm_d, nrm_q;
  logic                  deg_q;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      qc[l] = (dq[ND][l] > upn_pkg::ONE_Q30) ? upn_pkg::ONE_Q30 : dq[ND][l];
      if (ddeg[ND]) begin
        nrm_d[l] = '0;
      end else if (dneg[ND][l]) begin
        nrm_d[l] = DW'(0) - DW'(qc[l]);
      end else begin
        nrm_d[l] = DW'(qc[l]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv[ND];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nrm_q <= nrm_d;
      deg_q <= ddeg[ND];
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.normal_x   = nrm_q[0];
  assign out_o.normal_y   = nrm_q[1];
  assign out_o.normal_z   = nrm_q[2];
  assign out_o.degenerate = deg_q;

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.degenerate |->
      out_o.normal_x == '0 && out_o.normal_y == '0 && out_o.normal_z == '0)
    else $error("degenerate item carries a nonzero normal");

  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.degenerate |->
      out_o.normal_x != '0 || out_o.normal_y != '0 || out_o.normal_z != '0)
    else $error("non-degenerate item carries a zero normal");

  a_range_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.normal_x <= 32'sd1073741824 && out_o.normal_x >= -32'sd1073741824)
    else $error("normal x out of range");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input taken while result is stalled");
endmodule
`default_nettype wire
